[src/ntfs_rld_pkg.sv]
package ntfs_rld_pkg;

	// Field and register widths.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned NIB_W    = 4;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned HALF_W   = 32;
	localparam int unsigned SECT_W   = 13;
	localparam int unsigned CLUS_W   = 8;
	localparam int unsigned SCALE_W  = SECT_W + CLUS_W;
	localparam int unsigned PROD_W   = HALF_W + SCALE_W;
	localparam int unsigned CFG_W    = SECT_W;
	localparam int unsigned CFG_IDX_W = 1;

	// Header nibble that, like zero, marks the end of the list.
	localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;
	// Number of bytes kept from a field.
	localparam logic [NIB_W-1:0] MAX_FIELD_BYTES = 4'd8;

	// Reset values of the configuration registers.
	localparam logic [SECT_W-1:0] SECT_RESET = 13'd512;
	localparam logic [CLUS_W-1:0] CLUS_RESET = 8'd8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS = 1'b1;

	// Parse phase of the run list.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2,
		PH_ENDED  = 2'd3
	} phase_t;

	// Operand chosen for the shared multiplier.
	typedef enum logic [1:0] {
		MUL_OFF_LO = 2'd0,
		MUL_OFF_HI = 2'd1,
		MUL_LEN_LO = 2'd2,
		MUL_LEN_HI = 2'd3
	} mul_sel_t;

	// Controller states.
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCALE  = 7'b0000010,
		S_OFF_LO = 7'b0000100,
		S_OFF_HI = 7'b0001000,
		S_LEN_LO = 7'b0010000,
		S_LEN_HI = 7'b0100000,
		S_LOAD   = 7'b1000000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     take;
		logic     scale_en;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic run_done;
		logic term;
	} status_t;

endpackage

[src/ntfs_rld_ifs.sv]
// Input channel: one byte of the run list per transfer.
interface ntfs_rld_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [ntfs_rld_pkg::BYTE_W-1:0]       run_byte;
	logic                                  list_start;

	modport source (output valid, output run_byte, output list_start, input ready);
	modport sink (input valid, input run_byte, input list_start, output ready);
endinterface

// Output channel: one decoded run or end marker per transfer.
interface ntfs_rld_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [ntfs_rld_pkg::WORD_W-1:0]       byte_offset;
	logic [ntfs_rld_pkg::WORD_W-1:0]       byte_size;
	logic                                  list_end;

	modport source (output valid, output byte_offset, output byte_size, output list_end,
		input ready);
	modport sink (input valid, input byte_offset, input byte_size, input list_end,
		output ready);
endinterface

[src/ntfs_rld_ctrl.sv]
module ntfs_rld_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ntfs_rld_pkg::cmd_t     cmd,
	input  ntfs_rld_pkg::status_t  status
);

	ntfs_rld_pkg::state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 take;
	logic                 load_ok;

	assign in_ready  = (state_q == ntfs_rld_pkg::S_IDLE);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// The output register may be reloaded once it is empty or being drained.
	assign load_ok   = !out_valid_q || out_ready;

	// Next state: bytes are taken in idle; a finished run walks the scale and multiplier steps, then the output load.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ntfs_rld_pkg::S_IDLE: begin
				if (take && status.term) begin
					state_d = ntfs_rld_pkg::S_LOAD;
				end else if (take && status.run_done) begin
					state_d = ntfs_rld_pkg::S_SCALE;
				end
			end
			ntfs_rld_pkg::S_SCALE:  state_d = ntfs_rld_pkg::S_OFF_LO;
			ntfs_rld_pkg::S_OFF_LO: state_d = ntfs_rld_pkg::S_OFF_HI;
			ntfs_rld_pkg::S_OFF_HI: state_d = ntfs_rld_pkg::S_LEN_LO;
			ntfs_rld_pkg::S_LEN_LO: state_d = ntfs_rld_pkg::S_LEN_HI;
			ntfs_rld_pkg::S_LEN_HI: state_d = ntfs_rld_pkg::S_LOAD;
			ntfs_rld_pkg::S_LOAD: begin
				if (load_ok) begin
					state_d = ntfs_rld_pkg::S_IDLE;
				end
			end
			default: state_d = ntfs_rld_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		cmd.take     = take;
		cmd.scale_en = (state_q == ntfs_rld_pkg::S_SCALE);
		cmd.load_out = (state_q == ntfs_rld_pkg::S_LOAD) && load_ok;
		cmd.mul_sel  = ntfs_rld_pkg::MUL_OFF_LO;
		unique case (state_q)
			ntfs_rld_pkg::S_OFF_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ntfs_rld_pkg::MUL_OFF_LO;
			end
			ntfs_rld_pkg::S_OFF_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ntfs_rld_pkg::MUL_OFF_HI;
			end
			ntfs_rld_pkg::S_LEN_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ntfs_rld_pkg::MUL_LEN_LO;
			end
			ntfs_rld_pkg::S_LEN_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ntfs_rld_pkg::MUL_LEN_HI;
			end
			default: cmd.mul_en = 1'b0;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ntfs_rld_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/ntfs_rld_dp.sv]
module ntfs_rld_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [ntfs_rld_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ntfs_rld_pkg::CFG_W-1:0]            cfg_data,
	input  logic [ntfs_rld_pkg::BYTE_W-1:0]           run_byte,
	input  logic                                      list_start,
	input  ntfs_rld_pkg::cmd_t                        cmd,
	output ntfs_rld_pkg::status_t                     status,
	output logic [ntfs_rld_pkg::WORD_W-1:0]           byte_offset,
	output logic [ntfs_rld_pkg::WORD_W-1:0]           byte_size,
	output logic                                      list_end
);

	localparam int unsigned WW = ntfs_rld_pkg::WORD_W;
	localparam int unsigned HW = ntfs_rld_pkg::HALF_W;
	localparam int unsigned NW = ntfs_rld_pkg::NIB_W;

	// Sign-extends a short offset field of the given byte count.
	function automatic logic [WW-1:0] sext_delta(input logic [WW-1:0] d,
			input logic [NW-1:0] nbytes);
		logic [WW-1:0] r;
		r = d;
		for (int i = 1; i < 8; i++) begin
			if (nbytes == NW'(i) && d[8*i-1]) begin
				r = d | ({WW{1'b1}} << (8 * i));
			end
		end
		return r;
	endfunction

	// Configuration and parse state.
	logic [ntfs_rld_pkg::SECT_W-1:0]  sect_q;
	logic [ntfs_rld_pkg::CLUS_W-1:0]  clus_q;
	ntfs_rld_pkg::phase_t             phase_q;
	logic [NW-1:0]                    len_left_q, off_left_q, off_total_q, pos_q;
	logic [WW-1:0]                    len_acc_q, delta_q, run_clu_q;
	logic [ntfs_rld_pkg::SCALE_W-1:0] scale_q;
	logic [WW-1:0]                    off_res_q, len_res_q;
	logic                             end_res_q;
	logic [WW-1:0]                    offset_q, size_q;
	logic                             end_q;

	ntfs_rld_pkg::phase_t             phase_eff;
	logic [NW-1:0]                    lo_nib, hi_nib, len_left_nx, off_left_nx;
	logic                             term_hdr;
	logic [WW-1:0]                    placed, delta_new, delta_ext;
	logic [HW-1:0]                    mul_a;
	logic [ntfs_rld_pkg::PROD_W-1:0]  prod;

	// Byte decode: a list start forces the header phase.
	assign phase_eff   = list_start ? ntfs_rld_pkg::PH_HEADER : phase_q;
	assign lo_nib      = run_byte[NW-1:0];
	assign hi_nib      = run_byte[2*NW-1:NW];
	assign term_hdr    = (lo_nib == '0) || (lo_nib == ntfs_rld_pkg::NIB_MASK) ||
		(hi_nib == '0) || (hi_nib == ntfs_rld_pkg::NIB_MASK);
	assign len_left_nx = len_left_q - NW'(1);
	assign off_left_nx = off_left_q - NW'(1);

	// Bytes past the eighth of a field are dropped.
	assign placed    = (pos_q < ntfs_rld_pkg::MAX_FIELD_BYTES) ?
		(WW'(run_byte) << {pos_q[2:0], 3'b000}) : '0;
	assign delta_new = delta_q | placed;
	assign delta_ext = sext_delta(delta_new, off_total_q);

	assign status.term     = (phase_eff == ntfs_rld_pkg::PH_HEADER) && term_hdr;
	assign status.run_done = (phase_eff == ntfs_rld_pkg::PH_OFFSET) && (off_left_nx == '0);

	// Shared 32 by 21 bit multiplier over the halves of the cluster values.
	always_comb begin
		unique case (cmd.mul_sel)
			ntfs_rld_pkg::MUL_OFF_LO: mul_a = run_clu_q[HW-1:0];
			ntfs_rld_pkg::MUL_OFF_HI: mul_a = run_clu_q[WW-1:HW];
			ntfs_rld_pkg::MUL_LEN_LO: mul_a = len_acc_q[HW-1:0];
			ntfs_rld_pkg::MUL_LEN_HI: mul_a = len_acc_q[WW-1:HW];
			default:                  mul_a = '0;
		endcase
	end
	assign prod = ntfs_rld_pkg::PROD_W'(mul_a) * ntfs_rld_pkg::PROD_W'(scale_q);

	// Control state: configuration, parse phase and running cluster.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sect_q    <= ntfs_rld_pkg::SECT_RESET;
			clus_q    <= ntfs_rld_pkg::CLUS_RESET;
			phase_q   <= ntfs_rld_pkg::PH_HEADER;
			run_clu_q <= '0;
		end else begin
			if (cfg_we && cfg_index == ntfs_rld_pkg::REG_SECTOR_BYTES) begin
				sect_q <= cfg_data[ntfs_rld_pkg::SECT_W-1:0];
			end
			if (cfg_we && cfg_index == ntfs_rld_pkg::REG_CLUSTER_SECTORS) begin
				clus_q <= cfg_data[ntfs_rld_pkg::CLUS_W-1:0];
			end
			if (cmd.take) begin
				if (list_start) begin
					run_clu_q <= '0;
				end
				unique case (phase_eff)
					ntfs_rld_pkg::PH_HEADER: begin
						phase_q <= term_hdr ? ntfs_rld_pkg::PH_ENDED : ntfs_rld_pkg::PH_LENGTH;
					end
					ntfs_rld_pkg::PH_LENGTH: begin
						if (len_left_nx == '0) begin
							phase_q <= ntfs_rld_pkg::PH_OFFSET;
						end
					end
					ntfs_rld_pkg::PH_OFFSET: begin
						if (status.run_done) begin
							phase_q   <= ntfs_rld_pkg::PH_HEADER;
							run_clu_q <= run_clu_q + delta_ext;
						end
					end
					default: phase_q <= ntfs_rld_pkg::PH_ENDED;
				endcase
			end
		end
	end

	// Field counters and accumulators.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			unique case (phase_eff)
				ntfs_rld_pkg::PH_HEADER: begin
					len_left_q  <= lo_nib;
					off_left_q  <= hi_nib;
					off_total_q <= hi_nib;
					pos_q       <= '0;
					len_acc_q   <= '0;
					delta_q     <= '0;
				end
				ntfs_rld_pkg::PH_LENGTH: begin
					len_acc_q  <= len_acc_q | placed;
					len_left_q <= len_left_nx;
					pos_q      <= (len_left_nx == '0) ? '0 : pos_q + NW'(1);
				end
				ntfs_rld_pkg::PH_OFFSET: begin
					delta_q    <= delta_new;
					off_left_q <= off_left_nx;
					pos_q      <= status.run_done ? '0 : pos_q + NW'(1);
				end
				default: pos_q <= pos_q;
			endcase
		end
	end

	// Result registers: end marker, scale and the four partial products.
	always_ff @(posedge clk) begin
		if (cmd.take && status.term) begin
			off_res_q <= '0;
			len_res_q <= '0;
			end_res_q <= 1'b1;
		end
		if (cmd.scale_en) begin
			scale_q   <= ntfs_rld_pkg::SCALE_W'(sect_q) * ntfs_rld_pkg::SCALE_W'(clus_q);
			end_res_q <= 1'b0;
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				ntfs_rld_pkg::MUL_OFF_LO: off_res_q <= WW'(prod);
				ntfs_rld_pkg::MUL_OFF_HI: off_res_q[WW-1:HW] <= off_res_q[WW-1:HW] + prod[HW-1:0];
				ntfs_rld_pkg::MUL_LEN_LO: len_res_q <= WW'(prod);
				ntfs_rld_pkg::MUL_LEN_HI: len_res_q[WW-1:HW] <= len_res_q[WW-1:HW] + prod[HW-1:0];
				default: off_res_q <= off_res_q;
			endcase
		end
	end

	// Output register, loaded when the previous result has gone.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			offset_q <= off_res_q;
			size_q   <= len_res_q;
			end_q    <= end_res_q;
		end
	end

	assign byte_offset = offset_q;
	assign byte_size   = size_q;
	assign list_end    = end_q;

endmodule

[src/ntfs_run_list_decoder_core.sv]
// Decodes a data run list one byte per transfer into runs given in bytes. Header,
// length and offset bytes are taken at one per clock while the block is idle. On
// the last offset byte of a run the block stops taking bytes while it forms the
// cluster size in bytes, multiplies the low and high halves of the start and then
// the size on a single shared 32 by 21 bit multiplier for the low 64 bits of both
// products, and loads the output register; a terminating header only loads it.
// The output register holds a result while bytes continue to be taken, so the sink
// only stalls the block when a second result is ready before the first has been
// transferred. Configuration writes are meant for idle periods only.
module ntfs_run_list_decoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ntfs_rld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ntfs_rld_pkg::CFG_W-1:0]       cfg_data,
	ntfs_rld_in_if.sink                          byte_in,
	ntfs_rld_out_if.source                       run_out
);

	ntfs_rld_pkg::cmd_t    cmd;
	ntfs_rld_pkg::status_t status;

	// Sequencing of byte transfers, multiplier steps and output loads.
	ntfs_rld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_in.valid),
		.in_ready  (byte_in.ready),
		.out_valid (run_out.valid),
		.out_ready (run_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Parsing, cluster arithmetic and the output register.
	ntfs_rld_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.run_byte    (byte_in.run_byte),
		.list_start  (byte_in.list_start),
		.cmd         (cmd),
		.status      (status),
		.byte_offset (run_out.byte_offset),
		.byte_size   (run_out.byte_size),
		.list_end    (run_out.list_end)
	);

	// An end marker carries zero offset and size.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		run_out.valid && run_out.list_end |-> run_out.byte_offset == '0 &&
		run_out.byte_size == '0)
		else $error("end marker with non-zero payload");

	// After the last byte of a run the block is busy multiplying.
	a_busy_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in.valid && byte_in.ready && status.run_done |=> !byte_in.ready)
		else $error("byte taken during run arithmetic");

	// Only one source of result at a time: a finished run is never also a terminator.
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.run_done && status.term))
		else $error("run end and list end decoded together");

endmodule
